### sv/adsr_envelope_generator_core_macros.svh
// Assertion macros shared by the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define ADSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Checked at every edge, reset included.
`define ADSR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: reset check failed");
`else
`define ADSR_ASSERT(lbl, prop)
`define ADSR_ASSERT_RST(lbl, prop)
`endif
`endif

### sv/adsr_pkg.sv
// Package: widths, phase and register codes, shared structs for the envelope generator.
`default_nettype none
package adsr_pkg;

  localparam int unsigned LevelW   = 19;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned BaseW    = 18;
  localparam int unsigned SusW     = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned PhCodeW  = 3;

  localparam logic signed [LevelW-1:0] FullScale = 19'sd65536;

  // Reset values of the configuration registers
  localparam logic [CoefW-1:0]        AttackCoefRst   = 16'd0;
  localparam logic signed [BaseW-1:0] AttackBaseRst   = 18'sd85197;
  localparam logic [CoefW-1:0]        DecayCoefRst    = 16'd0;
  localparam logic signed [BaseW-1:0] DecayBaseRst    = 18'sd65530;
  localparam logic [CoefW-1:0]        ReleaseCoefRst  = 16'd0;
  localparam logic signed [BaseW-1:0] ReleaseBaseRst  = -18'sd7;
  localparam logic [SusW-1:0]         SustainLevelRst = 17'd65536;

  // Phase codes as seen on the result
  localparam logic [PhCodeW-1:0] PhCodeIdle    = 3'd0;
  localparam logic [PhCodeW-1:0] PhCodeAttack  = 3'd1;
  localparam logic [PhCodeW-1:0] PhCodeDecay   = 3'd2;
  localparam logic [PhCodeW-1:0] PhCodeSustain = 3'd3;
  localparam logic [PhCodeW-1:0] PhCodeRelease = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_ATTACK  = 5'b00010,
    PH_DECAY   = 5'b00100,
    PH_SUSTAIN = 5'b01000,
    PH_RELEASE = 5'b10000
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATTACK_COEF   = 3'd0,
    CFG_ATTACK_BASE   = 3'd1,
    CFG_DECAY_COEF    = 3'd2,
    CFG_DECAY_BASE    = 3'd3,
    CFG_RELEASE_COEF  = 3'd4,
    CFG_RELEASE_BASE  = 3'd5,
    CFG_SUSTAIN_LEVEL = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0]        attack_coef;
    logic signed [BaseW-1:0] attack_base;
    logic [CoefW-1:0]        decay_coef;
    logic signed [BaseW-1:0] decay_base;
    logic [CoefW-1:0]        release_coef;
    logic signed [BaseW-1:0] release_base;
    logic [SusW-1:0]         sustain_level;
  } cfg_t;

  typedef struct packed {
    logic signed [LevelW-1:0] level;
    phase_e                   phase;
    logic                     written;
  } step_t;

  function automatic logic [PhCodeW-1:0] phase_code(phase_e ph);
    logic [PhCodeW-1:0] c;
    unique case (ph)
      PH_IDLE:    c = PhCodeIdle;
      PH_ATTACK:  c = PhCodeAttack;
      PH_DECAY:   c = PhCodeDecay;
      PH_SUSTAIN: c = PhCodeSustain;
      PH_RELEASE: c = PhCodeRelease;
      default:    c = PhCodeIdle;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/adsr_cfg.sv
// Configuration register bank of the envelope generator.
`default_nettype none
module adsr_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [adsr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [adsr_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output adsr_pkg::cfg_t                       cfg_o
);

  adsr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adsr_pkg::CFG_ATTACK_COEF:   cfg_d.attack_coef   = cfg_wdata_i[15:0];
        adsr_pkg::CFG_ATTACK_BASE:   cfg_d.attack_base   = $signed(cfg_wdata_i[17:0]);
        adsr_pkg::CFG_DECAY_COEF:    cfg_d.decay_coef    = cfg_wdata_i[15:0];
        adsr_pkg::CFG_DECAY_BASE:    cfg_d.decay_base    = $signed(cfg_wdata_i[17:0]);
        adsr_pkg::CFG_RELEASE_COEF:  cfg_d.release_coef  = cfg_wdata_i[15:0];
        adsr_pkg::CFG_RELEASE_BASE:  cfg_d.release_base  = $signed(cfg_wdata_i[17:0]);
        adsr_pkg::CFG_SUSTAIN_LEVEL: cfg_d.sustain_level = cfg_wdata_i[16:0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coef   <= adsr_pkg::AttackCoefRst;
      cfg_q.attack_base   <= adsr_pkg::AttackBaseRst;
      cfg_q.decay_coef    <= adsr_pkg::DecayCoefRst;
      cfg_q.decay_base    <= adsr_pkg::DecayBaseRst;
      cfg_q.release_coef  <= adsr_pkg::ReleaseCoefRst;
      cfg_q.release_base  <= adsr_pkg::ReleaseBaseRst;
      cfg_q.sustain_level <= adsr_pkg::SustainLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### sv/adsr_step.sv
// One envelope tick: gate edge decode, multiply-add segment step, clamp and phase change.
`default_nettype none
module adsr_step (
  input  wire logic                                   gate_i,
  input  wire logic                                   last_gate_i,
  input  wire logic signed [adsr_pkg::LevelW-1:0]     level_i,
  input  wire adsr_pkg::phase_e                       phase_i,
  input  wire adsr_pkg::cfg_t                         cfg_i,
  output adsr_pkg::step_t                             step_o
);

  adsr_pkg::phase_e                     ph0;
  logic signed [adsr_pkg::BaseW-1:0]    base;
  logic [adsr_pkg::CoefW-1:0]           coef;
  logic signed [35:0]                   prod;
  logic signed [19:0]                   quot;
  logic signed [20:0]                   sum;
  logic signed [adsr_pkg::LevelW-1:0]   seg;
  logic signed [adsr_pkg::LevelW-1:0]   dec_full;
  logic signed [adsr_pkg::LevelW-1:0]   sus;

  // edge decode; the gate itself is stored by the caller every tick
  always_comb begin
    if (gate_i && !last_gate_i) begin
      ph0 = adsr_pkg::PH_ATTACK;
    end else if (!gate_i && last_gate_i) begin
      ph0 = adsr_pkg::PH_RELEASE;
    end else begin
      ph0 = phase_i;
    end
  end

  always_comb begin
    unique case (ph0)
      adsr_pkg::PH_ATTACK: begin
        base = cfg_i.attack_base;
        coef = cfg_i.attack_coef;
      end
      adsr_pkg::PH_DECAY: begin
        base = cfg_i.decay_base;
        coef = cfg_i.decay_coef;
      end
      adsr_pkg::PH_RELEASE: begin
        base = cfg_i.release_base;
        coef = cfg_i.release_coef;
      end
      default: begin
        base = '0;
        coef = '0;
      end
    endcase
  end

  // level*coef, floor by arithmetic shift, then saturate to the state range
  assign prod = $signed({{17{level_i[18]}}, level_i}) * $signed({20'd0, coef});
  assign quot = prod[35:16];
  assign sum  = $signed({{3{base[17]}}, base}) + $signed({quot[19], quot});

  always_comb begin
    if (sum > 21'sd262143) begin
      seg = 19'sd262143;
    end else if (sum < -21'sd262144) begin
      seg = -19'sd262144;
    end else begin
      seg = sum[18:0];
    end
  end

  // decay step from exactly full scale: full*coef>>16 is coef, no multiply
  assign dec_full = $signed({cfg_i.decay_base[17], cfg_i.decay_base})
                  + $signed({3'b000, cfg_i.decay_coef});
  assign sus      = $signed({2'b00, cfg_i.sustain_level});

  always_comb begin
    step_o.level   = level_i;
    step_o.phase   = ph0;
    step_o.written = 1'b0;
    unique case (ph0)
      adsr_pkg::PH_ATTACK: begin
        step_o.written = 1'b1;
        if (seg >= adsr_pkg::FullScale) begin
          if (dec_full <= sus) begin
            step_o.level = sus;
            step_o.phase = adsr_pkg::PH_SUSTAIN;
          end else begin
            step_o.level = dec_full;
            step_o.phase = adsr_pkg::PH_DECAY;
          end
        end else begin
          step_o.level = seg;
        end
      end
      adsr_pkg::PH_DECAY: begin
        step_o.written = 1'b1;
        if (seg <= sus) begin
          step_o.level = sus;
          step_o.phase = adsr_pkg::PH_SUSTAIN;
        end else begin
          step_o.level = seg;
        end
      end
      adsr_pkg::PH_RELEASE: begin
        step_o.written = 1'b1;
        if (seg <= 19'sd0) begin
          step_o.level = '0;
          step_o.phase = adsr_pkg::PH_IDLE;
        end else begin
          step_o.level = seg;
        end
      end
      default: ; // idle and sustain hold
    endcase
  end

endmodule
`default_nettype wire

### sv/adsr_out.sv
// Result register with skid stage and output byte formatting.
`default_nettype none
`include "adsr_envelope_generator_core_macros.svh"
module adsr_out (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire adsr_pkg::step_t               in_data_i,
  output logic                               in_ready_o,
  output logic                               m_valid_o,
  input  wire logic                          m_ready_i,
  output logic [7:0]                         m_level_o,
  output logic                               m_written_o,
  output logic [adsr_pkg::PhCodeW-1:0]       m_phase_o
);

  logic            main_valid_q, main_valid_d;
  logic            skid_valid_q, skid_valid_d;
  adsr_pkg::step_t main_q, main_d;
  adsr_pkg::step_t skid_q, skid_d;
  logic            pop;
  logic [25:0]     scaled;
  logic [9:0]      byte_wide;

  assign in_ready_o = !skid_valid_q;
  assign pop        = main_valid_q && m_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (in_valid_i) begin
        main_d = in_data_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (in_valid_i) begin
      if (!main_valid_q) begin
        main_d       = in_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // level*255 >> 16 as shift-subtract, saturated to a byte
  assign scaled    = {main_q.level[17:0], 8'h00} - {8'h00, main_q.level[17:0]};
  assign byte_wide = scaled[25:16];

  always_comb begin
    if (main_q.level <= 19'sd0) begin
      m_level_o = 8'h00;
    end else if (byte_wide > 10'd255) begin
      m_level_o = 8'hFF;
    end else begin
      m_level_o = byte_wide[7:0];
    end
  end

  assign m_valid_o   = main_valid_q;
  assign m_written_o = main_q.written;
  assign m_phase_o   = adsr_pkg::phase_code(main_q.phase);

  `ADSR_ASSERT(a_skid_needs_main, skid_valid_q |-> main_valid_q)
  `ADSR_ASSERT(a_skid_drains, skid_valid_q && m_ready_i |=> main_valid_q && !skid_valid_q)
  `ADSR_ASSERT_RST(a_reset_empty, !rst_ni |=> !main_valid_q && !skid_valid_q)

endmodule
`default_nettype wire

### sv/adsr_envelope_generator_core.sv
// Top level of the exponential ADSR envelope generator core.
// Results: the step of each accepted gate tick is registered in the result stage.
// Throughput: one tick per cycle while tready is high; combinational 19x17 mul-add, clamp.
// Stalls: register plus skid entry take one more tick while results wait, then tready drops.
// Reset (async, active low): envelope zero, phase idle, stored gate low, register defaults,
// result stage empty; no clearing pass.
`default_nettype none
`include "adsr_envelope_generator_core_macros.svh"
module adsr_envelope_generator_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // gate tick requests
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [0] gate, [7:1] zero
  // result requests
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [7:0] out_level
  output logic [3:0]                           m_axis_tuser,  // [0] level_written, [3:1] phase
  // register writes
  input  wire logic                            cfg_we_i,
  input  wire logic [adsr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [adsr_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  adsr_pkg::cfg_t                       cfg;
  adsr_pkg::step_t                      step;
  logic signed [adsr_pkg::LevelW-1:0]   level_q;
  adsr_pkg::phase_e                     phase_q;
  logic                                 last_gate_q;
  logic                                 s_ready;
  logic                                 s_accept;
  logic                                 gate;
  logic                                 out_written;
  logic [adsr_pkg::PhCodeW-1:0]         out_phase;
  logic                                 sus_steady;

  assign gate     = s_axis_tdata[0];
  assign s_accept = s_axis_tvalid && s_ready;

  adsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // next envelope state for the tick on the slave side
  adsr_step u_step (
    .gate_i      (gate),
    .last_gate_i (last_gate_q),
    .level_i     (level_q),
    .phase_i     (phase_q),
    .cfg_i       (cfg),
    .step_o      (step)
  );

  // envelope state moves only on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      phase_q     <= adsr_pkg::PH_IDLE;
      last_gate_q <= 1'b0;
    end else if (s_accept) begin
      level_q     <= step.level;
      phase_q     <= step.phase;
      last_gate_q <= gate;
    end
  end

  adsr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_accept),
    .in_data_i   (step),
    .in_ready_o  (s_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_level_o   (m_axis_tdata),
    .m_written_o (out_written),
    .m_phase_o   (out_phase)
  );

  assign s_axis_tready = s_ready;
  assign m_axis_tuser  = {out_phase, out_written};

  // accepted tick in sustain with no gate edge
  assign sus_steady = s_accept && phase_q == adsr_pkg::PH_SUSTAIN && gate == last_gate_q;

  // idle is only ever reached with the envelope at zero
  `ADSR_ASSERT(a_idle_is_zero, phase_q == adsr_pkg::PH_IDLE |-> level_q == 19'sd0)
  // a steady gate in sustain leaves the state alone
  `ADSR_ASSERT(a_sustain_holds, sus_steady |=> phase_q == adsr_pkg::PH_SUSTAIN && $stable(level_q))

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the ADSR envelope core: gate-tick requests in, level requests out.
module tb_top;
  import adsr_pkg::*;

  localparam int unsigned StallLimit   = 2000;  // cycles with no request moving on either side
  localparam int unsigned SettleCycles = 4;     // margin after the last level request

  typedef struct packed {
    logic [7:0]         out_level;
    logic               written;
    logic [PhCodeW-1:0] phase;
  } env_result_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [0] gate, [7:1] zero
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [7:0] out_level
  logic [3:0]          m_axis_tuser;        // [0] level_written, [3:1] phase
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  adsr_envelope_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow copy of the register file, kept in step with every write
  logic [CoefW-1:0]         atk_coef  = AttackCoefRst;
  logic signed [BaseW-1:0]  atk_base  = AttackBaseRst;
  logic [CoefW-1:0]         dec_coef  = DecayCoefRst;
  logic signed [BaseW-1:0]  dec_base  = DecayBaseRst;
  logic [CoefW-1:0]         rel_coef  = ReleaseCoefRst;
  logic signed [BaseW-1:0]  rel_base  = ReleaseBaseRst;
  logic [SusW-1:0]          sus_level = SustainLevelRst;

  // Envelope state as the core should hold it
  logic signed [LevelW-1:0] env_level = '0;
  logic [PhCodeW-1:0]       env_phase = PhCodeIdle;
  logic                     prev_gate = 1'b0;

  logic        gate_q[$];            // gate ticks waiting to be offered
  env_result_t envelope_due_q[$];    // predicted level requests, oldest first
  logic        in_taken     = 1'b0;  // gate request accepted at the last rising edge
  logic        steady       = 1'b0;  // no idling on either side while set
  int unsigned stall_cycles = 0;
  int unsigned mismatches   = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One multiply-add segment step: floor of the Q0.16 product, then saturate to 19 bits signed
  function automatic logic signed [LevelW-1:0] seg_update(logic signed [LevelW-1:0] lvl,
                                                          logic signed [BaseW-1:0]  base,
                                                          logic [CoefW-1:0]         coef);
    longint sum;
    sum = longint'(base) + ((longint'(lvl) * longint'(coef)) >>> 16);
    if (sum > 262143) sum = 262143;
    if (sum < -262144) sum = -262144;
    return sum[LevelW-1:0];
  endfunction

  function automatic logic [7:0] level_to_byte(logic signed [LevelW-1:0] lvl);
    longint v;
    if (lvl <= 0) return 8'd0;
    v = (longint'(lvl) * 255) >>> 16;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Advance the envelope by one tick and return the level request it should produce
  function automatic env_result_t envelope_tick(logic gate);
    env_result_t r;
    r.written = 1'b0;
    if (gate && !prev_gate) env_phase = PhCodeAttack;
    if (!gate && prev_gate) env_phase = PhCodeRelease;
    prev_gate = gate;
    if (env_phase == PhCodeAttack) begin
      env_level = seg_update(env_level, atk_base, atk_coef);
      // reaching full scale hands over to decay within the same tick
      if (env_level >= FullScale) begin
        env_level = FullScale;
        env_phase = PhCodeDecay;
      end else begin
        r.written = 1'b1;
      end
    end
    if (env_phase == PhCodeDecay) begin
      env_level = seg_update(env_level, dec_base, dec_coef);
      if (int'(env_level) <= int'(sus_level)) begin
        env_level = {2'b00, sus_level};
        env_phase = PhCodeSustain;
      end
      r.written = 1'b1;
    end
    if (env_phase == PhCodeRelease) begin
      env_level = seg_update(env_level, rel_base, rel_coef);
      if (env_level <= 0) begin
        env_level = '0;
        env_phase = PhCodeIdle;
      end
      r.written = 1'b1;
    end
    r.out_level = level_to_byte(env_level);
    r.phase     = env_phase;
    return r;
  endfunction

  // Gate driver: a request stays up until taken; ~31% idle cycles unless steady
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (gate_q.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
        s_axis_tdata  <= {7'd0, gate_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 31);
  end

  // Monitor: check level requests against the oldest prediction, predict on each gate
  // request taken, and stop the run if nothing moves for too long
  always @(posedge clk_i) begin
    env_result_t got;
    env_result_t want;
    logic        out_taken;
    out_taken = m_axis_tvalid && m_axis_tready;
    in_taken  = s_axis_tvalid && s_axis_tready;
    if (out_taken) begin
      got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[3:1]};
      if (envelope_due_q.size() == 0) begin
        $display("%0t: unexpected level request: level %0d written %0d phase %0d",
                 $time, got.out_level, got.written, got.phase);
        mismatches++;
      end else begin
        want = envelope_due_q.pop_front();
        if (got.out_level !== want.out_level) begin
          $display("%0t: out_level expected %0d actual %0d", $time, want.out_level,
                   got.out_level);
          mismatches++;
        end
        if (got.written !== want.written) begin
          $display("%0t: level_written expected %0d actual %0d", $time, want.written,
                   got.written);
          mismatches++;
        end
        if (got.phase !== want.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
          mismatches++;
        end
      end
    end
    if (in_taken) envelope_due_q.push_back(envelope_tick(s_axis_tdata[0]));
    if (in_taken || out_taken) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ATTACK_COEF:   atk_coef  = val[CoefW-1:0];
      CFG_ATTACK_BASE:   atk_base  = val[BaseW-1:0];
      CFG_DECAY_COEF:    dec_coef  = val[CoefW-1:0];
      CFG_DECAY_BASE:    dec_base  = val[BaseW-1:0];
      CFG_RELEASE_COEF:  rel_coef  = val[CoefW-1:0];
      CFG_RELEASE_BASE:  rel_base  = val[BaseW-1:0];
      CFG_SUSTAIN_LEVEL: sus_level = val[SusW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_setting(int ac, int ab, int dc, int db, int rc, int rb, int sl);
    write_reg(CFG_ATTACK_COEF,   CfgDataW'(ac));
    write_reg(CFG_ATTACK_BASE,   CfgDataW'(ab));
    write_reg(CFG_DECAY_COEF,    CfgDataW'(dc));
    write_reg(CFG_DECAY_BASE,    CfgDataW'(db));
    write_reg(CFG_RELEASE_COEF,  CfgDataW'(rc));
    write_reg(CFG_RELEASE_BASE,  CfgDataW'(rb));
    write_reg(CFG_SUSTAIN_LEVEL, CfgDataW'(sl));
  endtask

  // Mostly slow segments so every phase gets visited, now and then an extreme
  function automatic int pick_coef();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(65535);
      default: return $urandom_range(65535, 50000);
    endcase
  endfunction

  function automatic int pick_base(int lo, int hi);
    case ($urandom_range(9))
      0:       return -131072;
      1:       return 131071;
      2:       return int'($urandom_range(262143)) - 131072;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  task automatic load_random_setting();
    int sl;
    case ($urandom_range(9))
      0:       sl = 0;
      1:       sl = 65536;
      2:       sl = $urandom_range(131071);  // above full scale is allowed
      default: sl = $urandom_range(65536);
    endcase
    load_setting(pick_coef(), pick_base(1000, 20000), pick_coef(), pick_base(0, 5000),
                 pick_coef(), pick_base(-3000, -1), sl);
  endtask

  // A held note followed by a rest
  task automatic queue_note(int hold, int rest);
    repeat (hold) gate_q.push_back(1'b1);
    repeat (rest) gate_q.push_back(1'b0);
  endtask

  // Wait until every tick is taken and every level request has come back
  task automatic wait_idle();
    while (gate_q.size() != 0 || s_axis_tvalid || envelope_due_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int n);
    int queued;
    int hold;
    int rest;
    int k;
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(9) < 8) begin
        hold = $urandom_range(40, 1);
        rest = $urandom_range(40, 1);
        queue_note(hold, rest);
        queued += hold + rest;
      end else begin
        // chatter on the gate
        k = $urandom_range(6, 1);
        repeat (k) gate_q.push_back(1'($urandom_range(1)));
        queued += k;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: attack overshoots at once, decays straight to sustain, quick release
    gate_q.push_back(1'b0);
    queue_note(2, 2);
    wait_idle();

    // Slow segments: a partial attack, then release
    load_setting(60000, 8000, 60000, 2000, 60000, -500, 30000);
    queue_note(7, 5);
    wait_idle();

    // Top extremes: decay rising into saturation, sustain above full scale, release upwards
    load_setting(65535, 131071, 65535, 131071, 65535, 131071, 131071);
    queue_note(3, 2);
    wait_idle();

    // Bottom extremes: attack goes negative with rounding down and low saturation
    load_setting(65535, -131072, 0, 0, 65535, -131072, 0);
    queue_note(3, 1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      load_random_setting();
      steady = (ph == 3);
      run_random_phase(125);
    end
    steady = 1'b0;

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/adsr_pkg.sv
sv/adsr_cfg.sv
sv/adsr_step.sv
sv/adsr_out.sv
sv/adsr_envelope_generator_core.sv
tb/tb_top.sv
